FILE: rtl/core/cfg_pkg.sv
package cfg_pkg;

	// default timestamp width
	localparam int TIME_BITS_DEF = 32;

	// segment length and range bookkeeping
	localparam int MIN_PERIOD     = 50;
	localparam int RANGE_SEGMENTS = 5;
	localparam int SAT_MAX        = 255;

	// width of the ramp product handed to the divider
	localparam int PROD_BITS = 16;

	// brightness range codes
	localparam logic [1:0] RANGE_LOW  = 2'd0;
	localparam logic [1:0] RANGE_MID  = 2'd1;
	localparam logic [1:0] RANGE_HIGH = 2'd2;

	// divider pass selection
	localparam logic DIV_MODE_MOD  = 1'b0;
	localparam logic DIV_MODE_RAMP = 1'b1;

	typedef struct packed {
		logic start;
		logic mode;
	} div_ctrl_t;

	typedef struct packed {
		logic busy;
	} div_stat_t;

	// new target level within the given range; offset reduced by compare and subtract
	function automatic logic [7:0] draw_level(input logic [1:0] rng, input logic [5:0] r);
		logic [5:0] red;
		logic [7:0] lvl;
		begin
			red = r;
			lvl = 8'd0;
			unique case (rng)
				RANGE_LOW: begin
					if (r >= 6'd60)
						red = r - 6'd60;
					else if (r >= 6'd30)
						red = r - 6'd30;
					lvl = 8'd50 + {2'b00, red};
				end
				RANGE_MID: begin
					if (r >= 6'd40)
						red = r - 6'd40;
					lvl = 8'd107 + {2'b00, red};
				end
				default: begin
					if (r >= 6'd50)
						red = r - 6'd50;
					lvl = 8'd205 + {2'b00, red};
				end
			endcase
			draw_level = lvl;
		end
	endfunction

endpackage

FILE: rtl/core/cfg_serial_div.sv
module cfg_serial_div #(
	parameter int TIME_BITS = cfg_pkg::TIME_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  cfg_pkg::div_ctrl_t             ctrl,
	input  logic [TIME_BITS-1:0]           dividend,
	input  logic [7:0]                     divisor,
	output cfg_pkg::div_stat_t             stat,
	output logic [7:0]                     rem,
	output logic [cfg_pkg::PROD_BITS-1:0]  quo
);

	localparam int CW = $clog2(TIME_BITS + 1);
	localparam int PB = cfg_pkg::PROD_BITS;

	logic                 busy_q;
	logic [CW-1:0]        cnt_q;
	logic [7:0]           rem_q;
	logic [7:0]           div_q;
	logic [TIME_BITS-1:0] quo_q;

	logic [8:0] trial;
	logic       ge;

	// one restoring step per cycle
	always_comb begin
		trial = {rem_q, quo_q[TIME_BITS-1]};
		ge    = (trial >= {1'b0, div_q});
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (ctrl.start) begin
			busy_q <= 1'b1;
			cnt_q  <= (ctrl.mode == cfg_pkg::DIV_MODE_RAMP) ? CW'(PB) : CW'(TIME_BITS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1))
				busy_q <= 1'b0;
		end
	end

	// remainder and quotient shift register; ramp pass left-aligns the product
	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			rem_q <= '0;
			div_q <= divisor;
			if (ctrl.mode == cfg_pkg::DIV_MODE_RAMP)
				quo_q <= TIME_BITS'(dividend[PB-1:0]) << (TIME_BITS - PB);
			else
				quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? 8'(trial - {1'b0, div_q}) : trial[7:0];
			quo_q <= {quo_q[TIME_BITS-2:0], ge};
		end
	end

	assign stat.busy = busy_q;
	assign rem       = rem_q;
	assign quo       = quo_q[PB-1:0];

endmodule

FILE: rtl/core/candle_flicker_generator_core.sv
// Each input word passes through the single bit-serial divider, which runs a TIME_BITS-step
// modulo pass and then a 16-step ramp division; no new word is taken (in_stall high) until
// the result word has been registered.
// A finished result waits in the output register while the next word is taken.
// Reset (arst_n low, asynchronous): segment times and levels clear, five segments
// remain in the mid range, no result pending.
module candle_flicker_generator_core #(
	parameter int TIME_BITS = cfg_pkg::TIME_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] time_ms,
	input  logic [4:0]  rand_choice,
	input  logic [6:0]  rand_period,
	input  logic [5:0]  rand_level,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  brightness,
	output logic        segment_started
);

	localparam int TB_IN = (TIME_BITS < 32) ? TIME_BITS : 32;
	localparam int PB    = cfg_pkg::PROD_BITS;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_MOD  = 2'd1;
	localparam logic [1:0] S_DIV  = 2'd2;

	logic [1:0]           state_q;
	logic [TIME_BITS-1:0] seg_start_q;
	logic [TIME_BITS-1:0] seg_end_q;
	logic [7:0]           width_q;
	logic [7:0]           from_q;
	logic [7:0]           to_q;
	logic [2:0]           segs_q;
	logic [1:0]           range_q;
	logic                 started_q;
	logic                 out_valid_q;
	logic [7:0]           bright_q;
	logic                 seg_started_q;

	logic                 accept;
	logic [TIME_BITS-1:0] t;
	logic                 started;
	logic [1:0]           range_d;
	logic [2:0]           segs_d;
	logic [7:0]           width_d;
	logic [TIME_BITS-1:0] diff_d;

	logic                 rising;
	logic [7:0]           mul_a;
	logic [7:0]           mul_b;
	logic [PB-1:0]        prod;
	logic [7:0]           base;
	logic [PB:0]          sum;
	logic                 finish;

	cfg_pkg::div_ctrl_t   div_ctrl;
	cfg_pkg::div_stat_t   div_stat;
	logic [TIME_BITS-1:0] div_dividend;
	logic [7:0]           div_divisor;
	logic [7:0]           div_rem;
	logic [PB-1:0]        div_quo;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);

	// segment restart decision and new segment values
	always_comb begin
		t       = TIME_BITS'(time_ms[TB_IN-1:0]);
		started = (t == '0) || (seg_end_q == '0) || (t > seg_end_q);
		range_d = range_q;
		segs_d  = segs_q - 3'd1;
		if (segs_q == 3'd0) begin
			segs_d = 3'(cfg_pkg::RANGE_SEGMENTS - 1);
			if (rand_choice == 5'd0)
				range_d = cfg_pkg::RANGE_LOW;
			else if (rand_choice == 5'd1)
				range_d = cfg_pkg::RANGE_HIGH;
			else
				range_d = cfg_pkg::RANGE_MID;
		end
		width_d = started ? (8'(cfg_pkg::MIN_PERIOD) + {1'b0, rand_period}) : width_q;
		diff_d  = started ? '0 : (t - seg_start_q);
	end

	// ramp product from the reduced offset
	always_comb begin
		rising = (from_q < to_q);
		mul_a  = rising ? div_rem : (width_q - div_rem);
		mul_b  = rising ? (to_q - from_q) : (from_q - to_q);
		prod   = PB'(mul_a) * PB'(mul_b);
		base   = rising ? from_q : to_q;
		sum    = (PB + 1)'(div_quo) + (PB + 1)'(base);
	end

	assign finish = (state_q == S_DIV) && !div_stat.busy && (!out_valid_q || !out_stall);

	// divider hand-off: modulo pass on accept, ramp pass after it
	always_comb begin
		div_ctrl.start = accept || ((state_q == S_MOD) && !div_stat.busy);
		div_ctrl.mode  = (state_q == S_MOD) ? cfg_pkg::DIV_MODE_RAMP : cfg_pkg::DIV_MODE_MOD;
		if (state_q == S_MOD) begin
			div_dividend = TIME_BITS'(prod);
			div_divisor  = width_q - 8'd1;
		end else begin
			div_dividend = diff_d;
			div_divisor  = width_d;
		end
	end

	cfg_serial_div #(
		.TIME_BITS(TIME_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (div_ctrl),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.stat     (div_stat),
		.rem      (div_rem),
		.quo      (div_quo)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept)
						state_q <= S_MOD;
				end
				S_MOD: begin
					if (!div_stat.busy)
						state_q <= S_DIV;
				end
				S_DIV: begin
					if (finish)
						state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// segment state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_start_q <= '0;
			seg_end_q   <= '0;
			width_q     <= '0;
			from_q      <= '0;
			to_q        <= '0;
			segs_q      <= 3'(cfg_pkg::RANGE_SEGMENTS);
			range_q     <= cfg_pkg::RANGE_MID;
		end else if (accept && started) begin
			seg_start_q <= t;
			seg_end_q   <= t + TIME_BITS'(cfg_pkg::MIN_PERIOD) + TIME_BITS'(rand_period);
			width_q     <= width_d;
			from_q      <= to_q;
			to_q        <= cfg_pkg::draw_level(range_d, rand_level);
			segs_q      <= segs_d;
			range_q     <= range_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			started_q <= started;
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (finish)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			bright_q      <= (sum > (PB + 1)'(cfg_pkg::SAT_MAX)) ? 8'(cfg_pkg::SAT_MAX) : sum[7:0];
			seg_started_q <= started_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign brightness      = bright_q;
	assign segment_started = seg_started_q;

endmodule
